[src/cse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg
// shared types, constants and helpers of the contour segment extractor
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int DEF_MAX_ROW_LENGTH = 1024;
    localparam int DEF_MAX_ROWS       = 4096;
    localparam int DEF_FRACTION_BITS  = 16;

    localparam int SAMPLE_W    = 16;
    localparam int ROW_LEN_W   = 11;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int ROW_COORD_W = 28;
    localparam int COL_COORD_W = 26;

    localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL      = 1'b1;

    localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PLAN,
        ST_DIV_A,
        ST_DIV_B,
        ST_SEND
    } state_t;

    // cell corners: upper-left, upper, left, current
    typedef enum logic [1:0] {
        V_UL,
        V_U,
        V_L,
        V_X
    } vertex_t;

    typedef struct packed {
        vertex_t p;
        vertex_t q;
    } edge_t;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] numer;
        logic [SAMPLE_W-1:0] denom;
    } div_req_t;

    function automatic logic crosses(input logic signed [SAMPLE_W-1:0] za,
                                     input logic signed [SAMPLE_W-1:0] zb,
                                     input logic signed [SAMPLE_W-1:0] h);
        crosses = (za > h) != (zb > h);
    endfunction

    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SAMPLE_W-1:0] y);
        logic signed [SAMPLE_W:0] d;
        d = {x[SAMPLE_W-1], x} - {y[SAMPLE_W-1], y};
        abs_diff = d[SAMPLE_W] ? SAMPLE_W'(-d) : d[SAMPLE_W-1:0];
    endfunction

endpackage

[src/cse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/cse_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_div
// radix-2 restoring divider, quotient of (numer << FRACTION_BITS) / denom,
// for numer <= denom, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cse_div
    import cse_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  div_req_t               req,
    output logic                   done,
    output logic [FRACTION_BITS:0] quot
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 2);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   first_reg, first_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_W:0]      rem_reg, rem_next;
    logic [SAMPLE_W-1:0]    den_reg, den_next;
    logic [FRACTION_BITS:0] q_reg, q_next;
    logic [SAMPLE_W:0]      trial;
    logic                   ge;

    always_comb begin
        trial      = first_reg ? rem_reg : {rem_reg[SAMPLE_W-1:0], 1'b0};
        ge         = trial >= {1'b0, den_reg};
        busy_next  = busy_reg;
        done_next  = done_reg;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            first_next = 1'b1;
            cnt_next   = CNT_W'(FRACTION_BITS + 1);
            rem_next   = {1'b0, req.numer};
            den_next   = req.denom;
        end else if (busy_reg) begin
            first_next = 1'b0;
            rem_next   = ge ? trial - {1'b0, den_reg} : trial;
            q_next     = {q_reg[FRACTION_BITS-1:0], ge};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        first_reg <= first_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[src/contour_segment_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_segment_extractor
// isoline segments by marching triangles over a raster elevation grid
//
//   channel  dir  ports                          transfer
//   s_       in   elevation, start_of_frame      s_valid & s_ready
//   m_       out  segment endpoints, flags       m_valid & m_ready
//   cfg_     in   row_length, level              cfg_wr_en
//
// one sample at a time: idle, fetch and plan states for every sample, plus per
// segment two divisions in the shared divider and one transfer in the output
// stage, so a new sample is taken only once the last one is through
// line store read is registered; reset clears counters and handshakes
// a stalled m_ready holds the sequencer in its output state
// ----------------------------------------------------------------------------
module contour_segment_extractor
    import cse_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
    parameter int MAX_ROWS       = DEF_MAX_ROWS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [SAMPLE_W-1:0] s_elevation,
    input  logic                   s_start_of_frame,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ROW_COORD_W-1:0] m_start_row,
    output logic [COL_COORD_W-1:0] m_start_col,
    output logic [ROW_COORD_W-1:0] m_end_row,
    output logic [COL_COORD_W-1:0] m_end_col,
    output logic                   m_which_triangle,
    output logic                   m_last_segment
);

    localparam int CCW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int LW  = $clog2(MAX_ROW_LENGTH + 1);
    localparam int RCW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    state_t state_reg, state_next;

    logic [ROW_LEN_W-1:0]       row_length_reg;
    logic signed [SAMPLE_W-1:0] level_reg;
    logic [CCW-1:0]             col_reg, col_next;
    logic [RCW-1:0]             row_reg, row_next;
    logic [CCW-1:0]             c_reg, c_next;
    logic [RCW-1:0]             r_reg, r_next;
    logic                       cell_reg, cell_next;
    logic                       tri_reg, tri_next;
    logic signed [SAMPLE_W-1:0] cur_reg, cur_next;
    logic signed [SAMPLE_W-1:0] up_reg, up_next;
    logic signed [SAMPLE_W-1:0] left_reg, left_next;
    logic signed [SAMPLE_W-1:0] ul_reg, ul_next;
    logic                       m_valid_reg, m_valid_next;
    logic [ROW_COORD_W-1:0]     srow_reg, srow_next, erow_reg, erow_next;
    logic [COL_COORD_W-1:0]     scol_reg, scol_next, ecol_reg, ecol_next;
    logic                       mtri_reg, mtri_next, mlast_reg, mlast_next;

    logic [LW-1:0]       len;
    logic [CCW-1:0]      c0, c_cur;
    logic [RCW-1:0]      r0, r_cur, r_inc0, r_inc1;
    logic [LW-1:0]       c_plus;
    logic                s_xfer;
    logic [SAMPLE_W-1:0] rd_data;

    div_req_t               div_req;
    logic                   div_done;
    logic [FRACTION_BITS:0] div_q;

    vertex_t va [2], vb [2], vc [2];
    edge_t   ep1 [2], ep2 [2];
    logic    has_seg [2];
    edge_t   pt_edge, dv_edge;
    logic [ROW_COORD_W-1:0] pt_row;
    logic [COL_COORD_W-1:0] pt_col;

    function automatic logic signed [SAMPLE_W-1:0] z_of(input vertex_t v,
        input logic signed [SAMPLE_W-1:0] ul, input logic signed [SAMPLE_W-1:0] u,
        input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] x);
        case (v)
            V_UL:    z_of = ul;
            V_U:     z_of = u;
            V_L:     z_of = l;
            default: z_of = x;
        endcase
    endfunction

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= ROW_LENGTH_RESET;
            level_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROW_LENGTH: row_length_reg <= cfg_wr_data[ROW_LEN_W-1:0];
                REG_LEVEL:      level_reg      <= cfg_wr_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        if (row_length_reg < ROW_LEN_W'(2)) begin
            len = LW'(2);
        end else if (32'(row_length_reg) > MAX_ROW_LENGTH) begin
            len = LW'(MAX_ROW_LENGTH);
        end else begin
            len = LW'(row_length_reg);
        end
    end

    // raster position of the incoming sample
    always_comb begin
        c0     = s_start_of_frame ? '0 : col_reg;
        r0     = s_start_of_frame ? '0 : row_reg;
        r_inc0 = (32'(r0) + 1 >= MAX_ROWS) ? '0 : RCW'(32'(r0) + 1);
        if (LW'(c0) >= len) begin
            c_cur = '0;
            r_cur = r_inc0;
        end else begin
            c_cur = c0;
            r_cur = r0;
        end
        r_inc1 = (32'(r_cur) + 1 >= MAX_ROWS) ? '0 : RCW'(32'(r_cur) + 1);
        c_plus = LW'(c_cur) + 1'b1;
    end

    assign s_xfer = s_valid && s_ready;

    cse_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_ROW_LENGTH)
    ) u_line (
        .aclk   (aclk),
        .wr_en  (s_xfer),
        .wr_addr(c_cur),
        .wr_data(s_elevation),
        .rd_en  (s_xfer),
        .rd_addr(c_cur),
        .rd_data(rd_data)
    );

    // triangle corners and crossing edges
    assign va[0] = V_UL;
    assign vb[0] = V_L;
    assign vc[0] = V_U;
    assign va[1] = V_U;
    assign vb[1] = V_X;
    assign vc[1] = V_L;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            logic signed [SAMPLE_W-1:0] za, zb, zc;
            logic ab, bc, ac;
            za = z_of(va[k], ul_reg, up_reg, left_reg, cur_reg);
            zb = z_of(vb[k], ul_reg, up_reg, left_reg, cur_reg);
            zc = z_of(vc[k], ul_reg, up_reg, left_reg, cur_reg);
            ab = crosses(za, zb, level_reg);
            bc = crosses(zb, zc, level_reg);
            ac = crosses(za, zc, level_reg);
            has_seg[k] = 1'b1;
            if (ab && bc) begin
                ep1[k] = '{p: va[k], q: vb[k]};
                ep2[k] = '{p: vb[k], q: vc[k]};
            end else if (bc && ac) begin
                ep1[k] = '{p: va[k], q: vc[k]};
                ep2[k] = '{p: vb[k], q: vc[k]};
            end else begin
                ep1[k] = '{p: va[k], q: vb[k]};
                ep2[k] = '{p: va[k], q: vc[k]};
                has_seg[k] = ab && ac;
            end
        end
    end

    assign pt_edge = (state_reg == ST_DIV_B) ? ep2[tri_reg] : ep1[tri_reg];
    assign dv_edge = (state_reg == ST_DIV_A) ? ep2[tri_reg] : ep1[tri_reg];

    always_comb begin
        logic signed [SAMPLE_W-1:0] zp, zq;
        zp = z_of(dv_edge.p, ul_reg, up_reg, left_reg, cur_reg);
        zq = z_of(dv_edge.q, ul_reg, up_reg, left_reg, cur_reg);
        div_req.numer = abs_diff(level_reg, zp);
        div_req.denom = abs_diff(zq, zp);
        div_req.start = ((state_reg == ST_PLAN) && cell_reg && has_seg[tri_reg])
                     || ((state_reg == ST_DIV_A) && div_done);
    end

    cse_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .done   (div_done),
        .quot   (div_q)
    );

    // crossing point from the quotient, modulo the field widths
    always_comb begin
        logic pr, qr, pc, qc;
        logic [ROW_COORD_W-1:0] rbase, trow;
        logic [COL_COORD_W-1:0] cbase, tcol;
        pr = (pt_edge.p == V_UL) || (pt_edge.p == V_U);
        qr = (pt_edge.q == V_UL) || (pt_edge.q == V_U);
        pc = (pt_edge.p == V_UL) || (pt_edge.p == V_L);
        qc = (pt_edge.q == V_UL) || (pt_edge.q == V_L);
        rbase = (ROW_COORD_W'(r_reg) - ROW_COORD_W'(pr)) << FRACTION_BITS;
        cbase = (COL_COORD_W'(c_reg) - COL_COORD_W'(pc)) << FRACTION_BITS;
        trow  = ROW_COORD_W'(div_q);
        tcol  = COL_COORD_W'(div_q);
        if (pr && !qr) begin
            pt_row = rbase + trow;
        end else if (!pr && qr) begin
            pt_row = rbase - trow;
        end else begin
            pt_row = rbase;
        end
        if (pc && !qc) begin
            pt_col = cbase + tcol;
        end else if (!pc && qc) begin
            pt_col = cbase - tcol;
        end else begin
            pt_col = cbase;
        end
    end

    // sequencer
    always_comb begin
        logic finish;
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        c_next       = c_reg;
        r_next       = r_reg;
        cell_next    = cell_reg;
        tri_next     = tri_reg;
        cur_next     = cur_reg;
        up_next      = up_reg;
        left_next    = left_reg;
        ul_next      = ul_reg;
        m_valid_next = m_valid_reg;
        srow_next    = srow_reg;
        scol_next    = scol_reg;
        erow_next    = erow_reg;
        ecol_next    = ecol_reg;
        mtri_next    = mtri_reg;
        mlast_next   = mlast_reg;
        finish       = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    c_next    = c_cur;
                    r_next    = r_cur;
                    cell_next = (c_cur != '0) && (r_cur != '0);
                    cur_next  = s_elevation;
                    if (c_plus >= len) begin
                        col_next = '0;
                        row_next = r_inc1;
                    end else begin
                        col_next = CCW'(c_plus);
                        row_next = r_cur;
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                up_next    = rd_data;
                tri_next   = 1'b0;
                state_next = ST_PLAN;
            end
            ST_PLAN: begin
                if (cell_reg && has_seg[tri_reg]) begin
                    state_next = ST_DIV_A;
                end else if (!tri_reg) begin
                    tri_next = 1'b1;
                end else begin
                    finish = 1'b1;
                end
            end
            ST_DIV_A: begin
                if (div_done) begin
                    srow_next  = pt_row;
                    scol_next  = pt_col;
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (div_done) begin
                    erow_next    = pt_row;
                    ecol_next    = pt_col;
                    mtri_next    = tri_reg;
                    mlast_next   = tri_reg || !has_seg[1];
                    m_valid_next = 1'b1;
                    state_next   = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (!tri_reg) begin
                        tri_next   = 1'b1;
                        state_next = ST_PLAN;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (finish) begin
            ul_next    = up_reg;
            left_next  = cur_reg;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            left_reg    <= '0;
            ul_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            left_reg    <= left_next;
            ul_reg      <= ul_next;
            m_valid_reg <= m_valid_next;
        end
        c_reg     <= c_next;
        r_reg     <= r_next;
        cell_reg  <= cell_next;
        tri_reg   <= tri_next;
        cur_reg   <= cur_next;
        up_reg    <= up_next;
        srow_reg  <= srow_next;
        scol_reg  <= scol_next;
        erow_reg  <= erow_next;
        ecol_reg  <= ecol_next;
        mtri_reg  <= mtri_next;
        mlast_reg <= mlast_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_start_row      = srow_reg;
    assign m_start_col      = scol_reg;
    assign m_end_row        = erow_reg;
    assign m_end_col        = ecol_reg;
    assign m_which_triangle = mtri_reg;
    assign m_last_segment   = mlast_reg;

    // no new sample while a segment is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a segment is pending");

    // the lower-right triangle always closes the sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_which_triangle) |-> m_last_segment)
        else $error("lower-right segment not marked last");

    // interpolation offset stays within one grid step
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIV_A || state_reg == ST_DIV_B) && div_done && cell_reg)
            |-> (32'(div_q) <= (32'd1 << FRACTION_BITS)))
        else $error("interpolation offset out of range");

endmodule

[tb/contour_segment_extractor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_segment_extractor_tb
// drives elevation grids through the extractor under random handshake idling
// and compares every segment transfer with an in-bench marching triangles
// predictor; row length and level are changed between idle phases
// ----------------------------------------------------------------------------
module contour_segment_extractor_tb;
    import cse_pkg::*;

    localparam int MAX_LEN  = 1024;
    localparam int MAX_ROWS = 4096;
    localparam int FB       = 16;

    typedef struct packed {
        logic [ROW_COORD_W-1:0] start_row;
        logic [COL_COORD_W-1:0] start_col;
        logic [ROW_COORD_W-1:0] end_row;
        logic [COL_COORD_W-1:0] end_col;
        logic                   which_triangle;
        logic                   last_segment;
    } segment_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_ROW_LENGTH;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_elevation = '0;
    logic s_start_of_frame = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ROW_COORD_W-1:0] m_start_row, m_end_row;
    logic [COL_COORD_W-1:0] m_start_col, m_end_col;
    logic m_which_triangle, m_last_segment;

    contour_segment_extractor uut (.*);

    // predictor state
    logic signed [15:0] line_store [MAX_LEN];
    logic signed [15:0] left_z, upleft_z;
    int unsigned col_cnt, row_cnt, row_len_reg;
    logic signed [15:0] level_reg;
    segment_t pending_segments[$];

    int errors = 0;
    int send_idle = 0, recv_idle = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        segment_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_start_row, m_start_col, m_end_row, m_end_col,
                    m_which_triangle, m_last_segment};
            if (pending_segments.size() == 0) begin
                $error("unexpected segment transfer %h", got);
                errors++;
            end else begin
                want = pending_segments.pop_front();
                if (got.start_row !== want.start_row) begin
                    $error("start_row exp %h got %h", want.start_row, got.start_row);
                    errors++;
                end
                if (got.start_col !== want.start_col) begin
                    $error("start_col exp %h got %h", want.start_col, got.start_col);
                    errors++;
                end
                if (got.end_row !== want.end_row) begin
                    $error("end_row exp %h got %h", want.end_row, got.end_row);
                    errors++;
                end
                if (got.end_col !== want.end_col) begin
                    $error("end_col exp %h got %h", want.end_col, got.end_col);
                    errors++;
                end
                if (got.which_triangle !== want.which_triangle) begin
                    $error("which_triangle exp %b got %b", want.which_triangle,
                           got.which_triangle);
                    errors++;
                end
                if (got.last_segment !== want.last_segment) begin
                    $error("last_segment exp %b got %b", want.last_segment,
                           got.last_segment);
                    errors++;
                end
            end
        end
    end

    function automatic logic above(logic signed [15:0] z);
        return z > level_reg;
    endfunction

    function automatic void edge_point(int pr, int pc, logic signed [15:0] zp,
                                       int qr, int qc, logic signed [15:0] zq,
                                       output longint orow, output longint ocol);
        longint n, d, t;
        n = longint'(level_reg) - longint'(zp);
        d = longint'(zq) - longint'(zp);
        if (n < 0) n = -n;
        if (d < 0) d = -d;
        t = (d != 0) ? (n << FB) / d : 0;
        orow = longint'(pr) * (64'sd1 << FB) + longint'(qr - pr) * t;
        ocol = longint'(pc) * (64'sd1 << FB) + longint'(qc - pc) * t;
    endfunction

    function automatic void predict_segments(logic signed [15:0] cur, logic sof);
        int unsigned len, c, r;
        logic signed [15:0] up;
        int vr[3], vc[3];
        logic signed [15:0] vz[3];
        int e1, e2, n0;
        logic ab, bc, ac;
        longint p[4];
        segment_t s;
        len = row_len_reg;
        if (len < 2) len = 2;
        if (len > MAX_LEN) len = MAX_LEN;
        if (sof) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= len) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= MAX_ROWS) ? 0 : row_cnt + 1;
        end
        c = col_cnt;
        r = row_cnt;
        up = line_store[c % MAX_LEN];
        n0 = pending_segments.size();
        if (r >= 1 && c >= 1) begin
            for (int k = 0; k < 2; k++) begin
                if (k == 0) begin
                    vr = '{r - 1, r, r - 1}; vc = '{c - 1, c - 1, c};
                    vz = '{upleft_z, left_z, up};
                end else begin
                    vr = '{r - 1, r, r}; vc = '{c, c, c - 1};
                    vz = '{up, cur, left_z};
                end
                ab = above(vz[0]) != above(vz[1]);
                bc = above(vz[1]) != above(vz[2]);
                ac = above(vz[0]) != above(vz[2]);
                e1 = -1;
                if (ab && bc) begin e1 = 0; e2 = 1; end
                else if (bc && ac) begin e1 = 2; e2 = 1; end
                else if (ab && ac) begin e1 = 0; e2 = 2; end
                if (e1 >= 0) begin
                    for (int j = 0; j < 2; j++) begin
                        int ea, eb;
                        int ed;
                        ed = (j == 0) ? e1 : e2;
                        ea = (ed == 1) ? 1 : 0;
                        eb = (ed == 0) ? 1 : 2;
                        edge_point(vr[ea], vc[ea], vz[ea], vr[eb], vc[eb], vz[eb],
                                   p[2 * j], p[2 * j + 1]);
                    end
                    s.start_row = p[0][ROW_COORD_W-1:0];
                    s.start_col = p[1][COL_COORD_W-1:0];
                    s.end_row = p[2][ROW_COORD_W-1:0];
                    s.end_col = p[3][COL_COORD_W-1:0];
                    s.which_triangle = k[0];
                    s.last_segment = 1'b0;
                    pending_segments.insert(pending_segments.size(), s);
                end
            end
            if (pending_segments.size() > n0)
                pending_segments[pending_segments.size() - 1].last_segment = 1'b1;
        end
        upleft_z = up;
        left_z = cur;
        line_store[c % MAX_LEN] = cur;
        col_cnt = c + 1;
        if (col_cnt >= len) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= MAX_ROWS) ? 0 : r + 1;
        end
    endfunction

    task automatic send_sample(logic signed [15:0] z, logic sof);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_elevation <= z;
        s_start_of_frame <= sof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_segments(z, sof);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_segments.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wr_data <= d;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (a == REG_ROW_LENGTH) row_len_reg = d[ROW_LEN_W-1:0];
        else level_reg = d;
        @(negedge aclk);
    endtask

    // whole frame of random samples, rows filled before they are read
    task automatic send_frame(int len, int rows, int spread);
        for (int i = 0; i < len * rows; i++)
            send_sample(16'(int'(level_reg) + $urandom_range(2 * spread) - spread),
                        i == 0);
    endtask

    task automatic test_directed();
        logic signed [15:0] zs[9];
        write_reg(REG_ROW_LENGTH, 16'd3);
        write_reg(REG_LEVEL, 16'h0000);
        // checkerboard around level, then full range extremes
        zs = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh8000,
               16'sh0000, 16'sh7fff, 16'sh0001};
        for (int i = 0; i < 9; i++) send_sample(zs[i], i == 0);
        wait_idle();
        // level extremes: nothing strictly above max, samples alternating at and just above min
        write_reg(REG_LEVEL, 16'h7fff);
        for (int i = 0; i < 6; i++) send_sample(16'sh7fff, i == 0);
        wait_idle();
        write_reg(REG_LEVEL, 16'h8000);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh8000 : 16'sh8001, i == 0);
        wait_idle();
        // row length below minimum acts as two
        write_reg(REG_ROW_LENGTH, 16'd0);
        write_reg(REG_LEVEL, 16'd5);
        for (int i = 0; i < 4; i++) send_sample(i == 3 ? 16'sd9 : 16'sd1, i == 0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int len;
        for (int f = 0; f < 12; f++) begin
            len = $urandom_range(2, 6);
            write_reg(REG_ROW_LENGTH, 16'(len));
            write_reg(REG_LEVEL, 16'($urandom));
            send_frame(len, $urandom_range(2, 5), f[0] ? 30000 : 8);
            wait_idle();
        end
    endtask

    task automatic test_length_change();
        // shorten mid-row so the row ends at once
        write_reg(REG_ROW_LENGTH, 16'd6);
        write_reg(REG_LEVEL, 16'd0);
        send_frame(6, 2, 100);
        for (int i = 0; i < 4; i++) send_sample(16'($urandom), 1'b0);
        wait_idle();
        write_reg(REG_ROW_LENGTH, 16'd3);
        for (int i = 0; i < 9; i++) send_sample(16'($urandom_range(200) - 100), 1'b0);
        wait_idle();
    endtask

    task automatic test_long_rows();
        // row length above the maximum acts as the maximum
        write_reg(REG_ROW_LENGTH, 16'd2047);
        write_reg(REG_LEVEL, 16'd0);
        for (int i = 0; i < 40; i++) send_sample(16'($urandom_range(100) - 50), i == 0);
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        row_len_reg = 1024;
        level_reg = 0;
        left_z = 0;
        upleft_z = 0;
        col_cnt = 0;
        row_cnt = 0;
        send_idle = 12; recv_idle = 74;
        test_directed();
        test_random_frames();
        send_idle = 74; recv_idle = 12;
        test_random_frames();
        test_length_change();
        send_idle = 0; recv_idle = 0;
        test_random_frames();
        test_long_rows();
        wait_idle();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
